FILE: src/small_rsa_encrypt_decrypt_defines.svh
// Assertion macros for the small RSA block.
// Used by the top level; the clock is clk and the reset is rst.
`ifndef SMALL_RSA_ENCRYPT_DECRYPT_DEFINES_SVH
`define SMALL_RSA_ENCRYPT_DECRYPT_DEFINES_SVH
`ifndef SYNTH
`define SRSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srsa assertion failed");
`define SRSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srsa assertion failed");
`else
`define SRSA_ASSERT_IMP(lbl, ante, cons)
`define SRSA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: src/srsa_pkg.sv
// Shared constants, state types and status struct for the small RSA block.
// No dependencies.
`timescale 1ns / 1ps
package srsa_pkg;
  localparam int FACTOR_BITS = 15;
  localparam int N_BITS      = 2 * FACTOR_BITS;
  localparam int VALUE_BITS  = 30;
  localparam int W           = (N_BITS > VALUE_BITS) ? N_BITS : VALUE_BITS;
  localparam int T_BITS      = W + 2;
  localparam int CNT_BITS    = $clog2(W + 1);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PRIME_P = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_PRIME_Q = CFG_IDX_BITS'(1);
  localparam logic [FACTOR_BITS-1:0]  P_RESET = FACTOR_BITS'(61);
  localparam logic [FACTOR_BITS-1:0]  Q_RESET = FACTOR_BITS'(53);

  typedef enum logic [3:0] {
    K_START, K_MULN, K_MULPHI, K_CHECK, K_LOOP, K_DIV, K_MUL, K_EVAL, K_DONE
  } key_state_t;

  typedef enum logic [1:0] {X_IDLE, X_RED, X_LOOP, X_MUL} exp_state_t;

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_WAIT} top_state_t;

  typedef struct packed {
    logic done;
    logic err;
  } key_status_t;
endpackage

FILE: src/srsa_if.sv
// Input and output channel interfaces of the small RSA block.
// Depends on srsa_pkg for field widths.
`timescale 1ns / 1ps
interface srsa_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [srsa_pkg::VALUE_BITS-1:0]   value;
  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface srsa_out_if;
  logic                              valid;
  logic                              ready;
  logic [srsa_pkg::VALUE_BITS-1:0]   result;
  logic                              key_error;
  modport source (output valid, result, key_error, input ready);
  modport sink   (input valid, result, key_error, output ready);
endinterface

FILE: src/srsa_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on srsa_pkg.
`timescale 1ns / 1ps
module srsa_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [srsa_pkg::W-1:0]   dividend,
  input  logic [srsa_pkg::W-1:0]   divisor,
  output logic                     done,
  output logic [srsa_pkg::W-1:0]   quot,
  output logic [srsa_pkg::W-1:0]   rem
);
  logic                              busy;
  logic [srsa_pkg::CNT_BITS-1:0]     cnt;
  logic [srsa_pkg::W-1:0]            q_sh;
  logic [srsa_pkg::W-1:0]            r;
  logic [srsa_pkg::W-1:0]            dv;
  logic [srsa_pkg::W:0]              r_sh;
  logic [srsa_pkg::W:0]              diff;
  logic                              ge;

  always_comb begin
    r_sh = {r, q_sh[srsa_pkg::W-1]};
    diff = r_sh - {1'b0, dv};
    ge   = !diff[srsa_pkg::W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q_sh <= dividend;
        r    <= '0;
        dv   <= divisor;
      end else if (busy) begin
        r    <= ge ? diff[srsa_pkg::W-1:0] : r_sh[srsa_pkg::W-1:0];
        q_sh <= {q_sh[srsa_pkg::W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == srsa_pkg::CNT_BITS'(srsa_pkg::W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q_sh;
  assign rem  = r;
endmodule

FILE: src/srsa_key.sv
// Key derivation: n, phi, smallest coprime e and its inverse d by extended Euclid.
// Depends on srsa_pkg and srsa_div; quotient times t is a serial shift-add.
`timescale 1ns / 1ps
module srsa_key (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [srsa_pkg::FACTOR_BITS-1:0]    p,
  input  logic [srsa_pkg::FACTOR_BITS-1:0]    q,
  output srsa_pkg::key_status_t               status,
  output logic [srsa_pkg::W-1:0]              n,
  output logic [srsa_pkg::W-1:0]              e,
  output logic [srsa_pkg::W-1:0]              d
);
  localparam int FB = srsa_pkg::FACTOR_BITS;
  localparam int W  = srsa_pkg::W;
  localparam int TB = srsa_pkg::T_BITS;

  srsa_pkg::key_state_t state, state_next;
  logic                  err;
  logic [W-1:0]          phi, r0, r1, rn, mq, ecand;
  logic signed [TB-1:0]  t0, t1, mt, macc;
  logic [FB-1:0]         mul_a, mul_b;
  logic [2*FB-1:0]       prod;
  logic                  div_start, div_done;
  logic [W-1:0]          div_q, div_r;

  srsa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(r0), .divisor(r1),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  always_comb begin
    mul_a = (state == srsa_pkg::K_MULN) ? p : p - FB'(1);
    mul_b = (state == srsa_pkg::K_MULN) ? q : q - FB'(1);
    prod  = {{FB{1'b0}}, mul_a} * {{FB{1'b0}}, mul_b};
  end

  assign div_start = (state == srsa_pkg::K_LOOP) && (r1 != '0);

  always_ff @(posedge clk) begin
    if (rst) state <= srsa_pkg::K_START;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srsa_pkg::K_START:
        state_next = (p < FB'(2) || q < FB'(2)) ? srsa_pkg::K_DONE : srsa_pkg::K_MULN;
      srsa_pkg::K_MULN:   state_next = srsa_pkg::K_MULPHI;
      srsa_pkg::K_MULPHI: state_next = srsa_pkg::K_CHECK;
      srsa_pkg::K_CHECK:
        state_next = (phi < W'(3)) ? srsa_pkg::K_DONE : srsa_pkg::K_LOOP;
      srsa_pkg::K_LOOP:
        state_next = (r1 == '0) ? srsa_pkg::K_EVAL : srsa_pkg::K_DIV;
      srsa_pkg::K_DIV:
        if (div_done) state_next = srsa_pkg::K_MUL;
      srsa_pkg::K_MUL:
        if (mq == '0) state_next = srsa_pkg::K_LOOP;
      srsa_pkg::K_EVAL:
        state_next = (r0 == W'(1)) ? srsa_pkg::K_DONE : srsa_pkg::K_LOOP;
      srsa_pkg::K_DONE:   state_next = srsa_pkg::K_DONE;
      default:            state_next = srsa_pkg::K_START;
    endcase
    if (start) state_next = srsa_pkg::K_START;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err <= 1'b0;
    end else if (!start) begin
      unique case (state)
        srsa_pkg::K_START: begin
          err <= (p < FB'(2) || q < FB'(2));
          n   <= '0;
          e   <= '0;
          d   <= '0;
        end
        srsa_pkg::K_MULN:   n   <= W'(prod);
        srsa_pkg::K_MULPHI: phi <= W'(prod);
        srsa_pkg::K_CHECK: begin
          if (phi < W'(3)) begin
            err <= 1'b1;
            n   <= '0;
          end
          ecand <= W'(2);
          r0    <= phi;
          r1    <= W'(2);
          t0    <= '0;
          t1    <= TB'(1);
        end
        srsa_pkg::K_DIV: begin
          if (div_done) begin
            mq   <= div_q;
            rn   <= div_r;
            mt   <= t1;
            macc <= '0;
          end
        end
        srsa_pkg::K_MUL: begin
          if (mq == '0) begin
            t0 <= t1;
            t1 <= t0 - macc;
            r0 <= r1;
            r1 <= rn;
          end else begin
            if (mq[0]) macc <= macc + mt;
            mt <= mt <<< 1;
            mq <= mq >> 1;
          end
        end
        srsa_pkg::K_EVAL: begin
          if (r0 == W'(1)) begin
            e <= ecand;
            d <= t0[TB-1] ? W'(t0 + $signed({2'b00, phi})) : W'(t0);
          end else begin
            ecand <= ecand + W'(1);
            r0    <= phi;
            r1    <= ecand + W'(1);
            t0    <= '0;
            t1    <= TB'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign status.done = (state == srsa_pkg::K_DONE);
  assign status.err  = err;
endmodule

FILE: src/srsa_exp.sv
// Square-and-multiply modular exponentiation over a bit-serial add-and-double
// modular multiplier. Depends on srsa_pkg and srsa_div (input reduction).
`timescale 1ns / 1ps
module srsa_exp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [srsa_pkg::W-1:0]   value,
  input  logic [srsa_pkg::W-1:0]   n,
  input  logic [srsa_pkg::W-1:0]   exp,
  output logic                     done,
  output logic [srsa_pkg::W-1:0]   result
);
  localparam int W = srsa_pkg::W;

  srsa_pkg::exp_state_t state, state_next;
  logic [W-1:0]  base, acc, er, ma, mb, macc;
  logic          sq;
  logic [W:0]    sum1, dbl;
  logic [W-1:0]  m1, m2;
  logic          div_done;
  logic [W-1:0]  div_q, div_r;

  srsa_div u_div (
    .clk(clk), .rst(rst), .start(start), .dividend(value), .divisor(n),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  always_comb begin
    sum1 = {1'b0, macc} + {1'b0, ma};
    dbl  = {ma, 1'b0};
    m1   = (sum1 >= {1'b0, n}) ? W'(sum1 - {1'b0, n}) : W'(sum1);
    m2   = (dbl >= {1'b0, n}) ? W'(dbl - {1'b0, n}) : W'(dbl);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= srsa_pkg::X_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srsa_pkg::X_IDLE: if (start) state_next = srsa_pkg::X_RED;
      srsa_pkg::X_RED:  if (div_done) state_next = srsa_pkg::X_LOOP;
      srsa_pkg::X_LOOP: state_next = (er == '0) ? srsa_pkg::X_IDLE : srsa_pkg::X_MUL;
      srsa_pkg::X_MUL:  if (mb == '0) state_next = srsa_pkg::X_LOOP;
      default:          state_next = srsa_pkg::X_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        srsa_pkg::X_IDLE: begin
          if (start) er <= exp;
        end
        srsa_pkg::X_RED: begin
          if (div_done) begin
            base <= div_r;
            acc  <= W'(1);
          end
        end
        srsa_pkg::X_LOOP: begin
          if (er == '0) begin
            done <= 1'b1;
          end else begin
            sq   <= !er[0];
            ma   <= er[0] ? acc : base;
            mb   <= base;
            macc <= '0;
          end
        end
        srsa_pkg::X_MUL: begin
          if (mb == '0) begin
            if (sq) begin
              base <= macc;
              er   <= er >> 1;
            end else begin
              acc   <= macc;
              er[0] <= 1'b0;
            end
          end else begin
            if (mb[0]) macc <= m1;
            ma <= m2;
            mb <= mb >> 1;
          end
        end
        default: ;
      endcase
    end
  end

  assign result = acc;
endmodule

FILE: src/small_rsa_encrypt_decrypt.sv
// Textbook RSA on small numbers: encrypt (value^e mod n) or decrypt (value^d mod n).
// Channels: in_ch (cmd, value) and out_ch (result, key_error), valid/ready; a
// transfer happens on a clock edge with valid and ready both high.
// Config: cfg_we writes cfg_data to prime_p (index 0) or prime_q (index 1);
// other indexes are ignored. Each write restarts key derivation.
// After rst (synchronous, active high) p=61, q=53 and the key is derived anew.
// Key derivation runs a serial divider and a serial multiplier inside
// extended Euclid for each candidate e; in_ch.ready stays low until it finishes.
// One item at a time. An item is first reduced modulo n by the divider, then
// per exponent bit gets one modular square and, for a set bit, one multiply,
// each done by the bit-serial multiplier. With a key error the result is 0
// with key_error 1.
// The result sits in an output register; a new item can be taken while it
// waits, and a finished result is held until out_ch.ready.
// Depends on srsa_pkg, srsa_if, srsa_div, srsa_key, srsa_exp and the defines header.
`timescale 1ns / 1ps
`include "small_rsa_encrypt_decrypt_defines.svh"
module small_rsa_encrypt_decrypt (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [srsa_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [srsa_pkg::FACTOR_BITS-1:0]      cfg_data,
  srsa_in_if.sink                               in_ch,
  srsa_out_if.source                            out_ch
);
  localparam int W  = srsa_pkg::W;
  localparam int VB = srsa_pkg::VALUE_BITS;

  srsa_pkg::top_state_t    state, state_next;
  srsa_pkg::key_status_t   key_status;
  logic [srsa_pkg::FACTOR_BITS-1:0] prime_p, prime_q;
  logic [W-1:0]            key_n, key_e, key_d;
  logic                    key_start, in_xfer, exp_start, exp_done, out_load;
  logic [W-1:0]            exp_result;
  logic [VB-1:0]           hold_res;
  logic                    hold_err;

  assign key_start = cfg_we &&
    (cfg_index == srsa_pkg::REG_PRIME_P || cfg_index == srsa_pkg::REG_PRIME_Q);

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_p <= srsa_pkg::P_RESET;
      prime_q <= srsa_pkg::Q_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srsa_pkg::REG_PRIME_P: prime_p <= cfg_data;
        srsa_pkg::REG_PRIME_Q: prime_q <= cfg_data;
        default: ;
      endcase
    end
  end

  srsa_key u_key (
    .clk(clk), .rst(rst), .start(key_start), .p(prime_p), .q(prime_q),
    .status(key_status), .n(key_n), .e(key_e), .d(key_d)
  );

  assign in_ch.ready = (state == srsa_pkg::T_IDLE) && key_status.done;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign exp_start   = in_xfer && !key_status.err;

  srsa_exp u_exp (
    .clk(clk), .rst(rst), .start(exp_start), .value(W'(in_ch.value)), .n(key_n),
    .exp(in_ch.cmd ? key_d : key_e), .done(exp_done), .result(exp_result)
  );

  assign out_load = (state == srsa_pkg::T_WAIT) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) state <= srsa_pkg::T_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srsa_pkg::T_IDLE:
        if (in_xfer) state_next = key_status.err ? srsa_pkg::T_WAIT : srsa_pkg::T_RUN;
      srsa_pkg::T_RUN:  if (exp_done) state_next = srsa_pkg::T_WAIT;
      srsa_pkg::T_WAIT: if (out_load) state_next = srsa_pkg::T_IDLE;
      default:          state_next = srsa_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer && key_status.err) begin
      hold_res <= '0;
      hold_err <= 1'b1;
    end else if (state == srsa_pkg::T_RUN && exp_done) begin
      hold_res <= VB'(exp_result);
      hold_err <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid     <= 1'b1;
      out_ch.result    <= hold_res;
      out_ch.key_error <= hold_err;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  `SRSA_ASSERT_IMP(a_err_zero, out_ch.valid && out_ch.key_error, out_ch.result == '0)
  `SRSA_ASSERT_IMP(a_res_below_n, out_ch.valid && !out_ch.key_error, W'(out_ch.result) < key_n)
  `SRSA_ASSERT_NXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready)
  `SRSA_ASSERT_IMP(a_key_ok, key_status.done && !key_status.err, key_e >= W'(2) && key_d != '0)
endmodule
